[sv/assert_macros.svh]
// Assertion macros for the blocks that check their own behavior.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent in this cycle implies the consequent in the same cycle.
`define FPD_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Antecedent in this cycle implies the consequent in the next cycle.
`define FPD_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[sv/fpd_pkg.sv]
// Constants, types and the arctangent table of the FM phase-difference demodulator.
package fpd_pkg;

   localparam int SAMPLE_WIDTH   = 16;
   localparam int ANGLE_WIDTH    = 16;
   localparam int CORDIC_STEPS   = 16;
   localparam int PHASE_WIDTH    = 16;
   localparam int ACC_WIDTH      = 32;
   localparam int PRESCALE_SHIFT = 16;
   // Four guard bits cover the sign, the negation of the most negative sample
   // and the CORDIC gain of about 1.65 on a vector of length up to sqrt(2).
   localparam int DATA_WIDTH     = SAMPLE_WIDTH + PRESCALE_SHIFT + 4;
   localparam int STEP_WIDTH     = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
   localparam int TABLE_WIDTH    = 5;

   localparam logic [ACC_WIDTH-1:0] ACC_PI = {1'b1, {(ACC_WIDTH-1){1'b0}}};

   typedef enum logic [1:0] {
      CS_IDLE,
      CS_ITER,
      CS_DONE
   } cordic_state_type;

   typedef struct packed {
      logic start;
      logic ack;
   } cordic_ctrl_type;

   typedef struct packed {
      logic idle;
      logic done;
   } cordic_stat_type;

   // atan(2^-k) in units where 2^32 is one full turn, rounded to nearest.
   function automatic logic [ACC_WIDTH-1:0] atan_turn(input logic [TABLE_WIDTH-1:0] k);
      logic [ACC_WIDTH-1:0] v;
      case (k)
         5'd0:    v = 32'h20000000;
         5'd1:    v = 32'h12E4051E;
         5'd2:    v = 32'h09FB385B;
         5'd3:    v = 32'h051111D4;
         5'd4:    v = 32'h028B0D43;
         5'd5:    v = 32'h0145D7E1;
         5'd6:    v = 32'h00A2F61E;
         5'd7:    v = 32'h00517C55;
         5'd8:    v = 32'h0028BE53;
         5'd9:    v = 32'h00145F2F;
         5'd10:   v = 32'h000A2F98;
         5'd11:   v = 32'h000517CC;
         5'd12:   v = 32'h00028BE6;
         5'd13:   v = 32'h000145F3;
         5'd14:   v = 32'h0000A2FA;
         5'd15:   v = 32'h0000517D;
         5'd16:   v = 32'h000028BE;
         5'd17:   v = 32'h0000145F;
         5'd18:   v = 32'h00000A30;
         5'd19:   v = 32'h00000518;
         5'd20:   v = 32'h0000028C;
         5'd21:   v = 32'h00000146;
         5'd22:   v = 32'h000000A3;
         5'd23:   v = 32'h00000051;
         5'd24:   v = 32'h00000029;
         5'd25:   v = 32'h00000014;
         5'd26:   v = 32'h0000000A;
         5'd27:   v = 32'h00000005;
         5'd28:   v = 32'h00000003;
         5'd29:   v = 32'h00000001;
         5'd30:   v = 32'h00000001;
         default: v = 32'h00000000;
      endcase
      return v;
   endfunction

endpackage

[sv/fpd_cordic.sv]
// Iterative vectoring CORDIC that finds the binary-angle phase of one sample.
module fpd_cordic
   import fpd_pkg::*;
(
   input  logic                           clock,
   input  logic                           reset,
   input  cordic_ctrl_type                ctrl,
   input  logic signed [SAMPLE_WIDTH-1:0] in_x,
   input  logic signed [SAMPLE_WIDTH-1:0] in_y,
   output cordic_stat_type                stat,
   output logic [ANGLE_WIDTH-1:0]         phase
);

   localparam logic [STEP_WIDTH-1:0] LAST_STEP = STEP_WIDTH'(CORDIC_STEPS - 1);
   localparam logic [ACC_WIDTH-1:0]  ROUND_INC =
      (ANGLE_WIDTH >= ACC_WIDTH) ? '0 : (ACC_WIDTH'(1) << (ACC_WIDTH - 1 - ANGLE_WIDTH));

   cordic_state_type              state_ff, state_in;
   logic [STEP_WIDTH-1:0]         step_ff, step_in;
   logic signed [DATA_WIDTH-1:0]  x_ff, x_in;
   logic signed [DATA_WIDTH-1:0]  y_ff, y_in;
   logic [ACC_WIDTH-1:0]          z_ff, z_in;

   logic signed [DATA_WIDTH-1:0]  x_start, y_start, x_shift, y_shift;
   logic [ACC_WIDTH-1:0]          step_angle, z_round;
   logic                          y_pos, y_neg;

   assign x_start    = DATA_WIDTH'(in_x) <<< PRESCALE_SHIFT;
   assign y_start    = DATA_WIDTH'(in_y) <<< PRESCALE_SHIFT;
   assign x_shift    = x_ff >>> step_ff;
   assign y_shift    = y_ff >>> step_ff;
   assign step_angle = atan_turn(TABLE_WIDTH'(step_ff));
   assign y_neg      = y_ff[DATA_WIDTH-1];
   assign y_pos      = !y_neg && (y_ff != '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CS_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in;
      y_ff <= y_in;
      z_ff <= z_in;
   end

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      z_in     = z_ff;
      unique case (state_ff)
         CS_IDLE: begin
            if (ctrl.start) begin
               // Left half plane: rotate by pi first so the vector has x >= 0.
               if (x_start[DATA_WIDTH-1]) begin
                  x_in = -x_start;
                  y_in = -y_start;
                  z_in = ACC_PI;
               end else begin
                  x_in = x_start;
                  y_in = y_start;
                  z_in = '0;
               end
               step_in  = '0;
               state_in = CS_ITER;
            end
         end
         CS_ITER: begin
            if (y_pos) begin
               x_in = x_ff + y_shift;
               y_in = y_ff - x_shift;
               z_in = z_ff + step_angle;
            end else if (y_neg) begin
               x_in = x_ff - y_shift;
               y_in = y_ff + x_shift;
               z_in = z_ff - step_angle;
            end
            if (step_ff == LAST_STEP) begin
               state_in = CS_DONE;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         CS_DONE: begin
            if (ctrl.ack) begin
               state_in = CS_IDLE;
            end
         end
         default: begin
            state_in = CS_IDLE;
         end
      endcase
   end

   // Round the full-turn accumulator to the output angle width, half up.
   assign z_round   = z_ff + ROUND_INC;
   assign phase     = z_round[ACC_WIDTH-1 -: ANGLE_WIDTH];
   assign stat.idle = (state_ff == CS_IDLE);
   assign stat.done = (state_ff == CS_DONE);

endmodule

[sv/fm_phase_difference_demodulator.sv]
// Top level of the FM phase-difference demodulator: handshakes, phase memory and output beat.
// A result beat is registered once the CORDIC has loaded its input beat, run its 16
// iterative steps and handed the phase off. A new input beat is taken only when the
// CORDIC is idle again after that hand-off; a stalled result beat delays the next hand-off.
// Reset (synchronous, active high) empties the output, idles the CORDIC and forgets
// the previous phase, so the first sample afterwards only loads the phase.
`include "assert_macros.svh"

module fm_phase_difference_demodulator
   import fpd_pkg::*;
(
   input  logic                           clock,
   input  logic                           reset,
   input  logic signed [SAMPLE_WIDTH-1:0] req_i_sample,
   input  logic signed [SAMPLE_WIDTH-1:0] req_q_sample,
   input  logic                           req_block_start,
   input  logic                           req_valid,
   output logic                           req_ready,
   output logic signed [PHASE_WIDTH-1:0]  rsp_phase_step,
   output logic                           rsp_valid,
   input  logic                           rsp_ready
);

   cordic_ctrl_type          cordic_ctl;
   cordic_stat_type          cordic_st;
   logic [ANGLE_WIDTH-1:0]   cur_phase;

   logic                     start_ff, start_in;
   logic                     have_last_ff, have_last_in;
   logic [ANGLE_WIDTH-1:0]   last_phase_ff, last_phase_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [PHASE_WIDTH-1:0]   rsp_phase_step_ff, rsp_phase_step_in;

   logic                     no_result;
   logic                     slot_free;
   logic                     emit;
   logic [ANGLE_WIDTH-1:0]   phase_diff;

   // The CORDIC runs one sample at a time; its idle state is the only time a
   // new sample can be taken.
   fpd_cordic u_cordic (
      .clock (clock),
      .reset (reset),
      .ctrl  (cordic_ctl),
      .in_x  (req_i_sample),
      .in_y  (req_q_sample),
      .stat  (cordic_st),
      .phase (cur_phase)
   );

   assign req_ready        = cordic_st.idle;
   assign cordic_ctl.start = req_valid && req_ready;

   // A block start, or no phase held yet, only loads the phase. Otherwise the
   // finished phase waits in the CORDIC until the output register can take it.
   assign no_result      = start_ff || !have_last_ff;
   assign slot_free      = !rsp_valid_ff || rsp_ready;
   assign cordic_ctl.ack = cordic_st.done && (no_result || slot_free);
   assign emit           = cordic_ctl.ack && !no_result;

   // Binary-angle subtraction wraps modulo one turn into [-pi, pi) by itself.
   assign phase_diff = cur_phase - last_phase_ff;

   always_comb begin
      start_in          = cordic_ctl.start ? req_block_start : start_ff;
      have_last_in      = have_last_ff || cordic_ctl.ack;
      last_phase_in     = cordic_ctl.ack ? cur_phase : last_phase_ff;
      rsp_phase_step_in = emit ? PHASE_WIDTH'(phase_diff) : rsp_phase_step_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         have_last_ff  <= 1'b0;
         last_phase_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         have_last_ff  <= have_last_in;
         last_phase_ff <= last_phase_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      start_ff          <= start_in;
      rsp_phase_step_ff <= rsp_phase_step_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_phase_step = rsp_phase_step_ff;

   // An accepted sample keeps the block busy in the following cycle.
   `FPD_ASSERT_NEXT(a_busy_after_accept, req_valid && req_ready, !req_ready, "ready after accept")
   // A new result beat only comes from a finished CORDIC run.
   `FPD_ASSERT_NOW(a_result_from_done, $rose(rsp_valid_ff), $past(cordic_st.done), "no CORDIC")
   // Once a phase is held it stays held until reset.
   `FPD_ASSERT_NEXT(a_have_last_sticky, have_last_ff, have_last_ff, "previous phase lost")

endmodule
